/* rtl/core/delta_rice_byte_decoder_unit_defines.svh */
// Assertion helpers for the decoder modules; drbd_outq includes them.
// Each expects i_clk and i_rst_n in the enclosing module.
`ifndef DELTA_RICE_BYTE_DECODER_UNIT_DEFINES_SVH
`define DELTA_RICE_BYTE_DECODER_UNIT_DEFINES_SVH

// cond must hold at every edge out of reset
`define DRBD_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("drbd check failed");

// pre at one edge implies post at the next edge
`define DRBD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("drbd check failed");

`endif

/* rtl/core/drbd_pkg.sv */
package drbd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int BYTE_W    = 8;
    localparam int QCNT_W    = 12;
    localparam int RICE_K    = 4;

    // result queue between the decode step and the output channel
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_QW   = $clog2(QDEPTH + 1);
    localparam int PUSH_W    = 2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        t_sample sample;
        logic    final_s;
    } t_res;

    // up to two results per input beat, packed from e0 upward
    typedef struct packed {
        logic [PUSH_W-1:0] n;
        t_res              e0;
        t_res              e1;
    } t_push;

endpackage

/* rtl/core/drbd_if.sv */
interface drbd_in_if;
    logic                            valid;
    logic                            ready;
    logic [drbd_pkg::BYTE_W-1:0]     code_byte;
    logic                            stream_end;

    modport source (output valid, output code_byte, output stream_end, input ready);
    modport sink   (input valid, input code_byte, input stream_end, output ready);
endinterface

interface drbd_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [drbd_pkg::SAMPLE_W-1:0] pcm_sample;
    logic                            final_sample;

    modport source (output valid, output pcm_sample, output final_sample, input ready);
    modport sink   (input valid, input pcm_sample, input final_sample, output ready);
endinterface

/* rtl/core/drbd_step.sv */
module drbd_step #(
    parameter int RICE_K = drbd_pkg::RICE_K
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [drbd_pkg::BYTE_W-1:0]   i_byte,
    input  logic                          i_end,
    input  drbd_pkg::t_sample             i_start,
    output drbd_pkg::t_push               o_push
);

    localparam int QSH_W = drbd_pkg::QCNT_W + RICE_K;

    logic                          r_phase, n_phase;
    logic [drbd_pkg::QCNT_W-1:0]   r_q, n_q;
    drbd_pkg::t_sample             r_prev, n_prev;
    logic                          r_started, n_started;

    drbd_pkg::t_sample             base;
    logic [QSH_W-1:0]              qsh_wide;
    logic [drbd_pkg::SAMPLE_W-1:0] qshift;
    logic [drbd_pkg::SAMPLE_W-1:0] mag;
    logic [drbd_pkg::SAMPLE_W-1:0] diff;
    logic [RICE_K-1:0]             low;
    logic                          dec_vld;
    drbd_pkg::t_res                dec;
    drbd_pkg::t_res                start_res;

    always_comb begin
        base      = r_started ? r_prev : i_start;
        qsh_wide  = {r_q, {RICE_K{1'b0}}};
        qshift    = drbd_pkg::SAMPLE_W'(qsh_wide);
        low       = i_byte[RICE_K-1:0];
        mag       = qshift | drbd_pkg::SAMPLE_W'(low);
        diff      = i_byte[RICE_K] ? (~mag + drbd_pkg::SAMPLE_W'(1)) : mag;

        n_phase   = r_phase;
        n_q       = r_q;
        n_prev    = base;
        n_started = 1'b1;
        dec_vld   = 1'b0;
        dec.sample  = base;
        dec.final_s = 1'b1;

        if (!r_phase) begin
            if (i_byte == '0) begin
                n_q     = r_q + drbd_pkg::QCNT_W'(1);
                dec_vld = i_end;
            end else begin
                n_phase = 1'b1;
                if (i_end) begin
                    // stream ends on the marker: quotient part only
                    n_prev     = base + drbd_pkg::t_sample'(qshift);
                    dec_vld    = 1'b1;
                    dec.sample = base + drbd_pkg::t_sample'(qshift);
                end
            end
        end else begin
            n_prev      = base + drbd_pkg::t_sample'(diff);
            dec_vld     = 1'b1;
            dec.sample  = base + drbd_pkg::t_sample'(diff);
            dec.final_s = i_end;
            n_phase     = 1'b0;
            n_q         = '0;
        end

        if (i_end) begin
            n_phase   = 1'b0;
            n_q       = '0;
            n_started = 1'b0;
        end

        start_res.sample  = i_start;
        start_res.final_s = 1'b0;

        // start sample goes ahead of the decoded one
        if (!r_started) begin
            o_push.n  = dec_vld ? drbd_pkg::PUSH_W'(2) : drbd_pkg::PUSH_W'(1);
            o_push.e0 = start_res;
            o_push.e1 = dec;
        end else begin
            o_push.n  = dec_vld ? drbd_pkg::PUSH_W'(1) : drbd_pkg::PUSH_W'(0);
            o_push.e0 = dec;
            o_push.e1 = dec;
        end
        if (!i_fire) begin
            o_push.n = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 1'b0;
            r_q       <= '0;
            r_prev    <= '0;
            r_started <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_q       <= n_q;
            r_prev    <= n_prev;
            r_started <= n_started;
        end
    end

endmodule

/* rtl/core/drbd_outq.sv */
`include "delta_rice_byte_decoder_unit_defines.svh"

module drbd_outq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  drbd_pkg::t_push               i_push,
    output logic                          o_room2,
    drbd_out_if.source                    o_out
);

    drbd_pkg::t_res                     r_mem [drbd_pkg::QDEPTH];
    logic [drbd_pkg::QPTR_W-1:0]        r_wr, r_rd;
    logic [drbd_pkg::QCNT_QW-1:0]       r_count, n_count;
    logic [drbd_pkg::QPTR_W-1:0]        wr1;
    logic                               pop;

    assign o_room2          = (r_count <= drbd_pkg::QCNT_QW'(drbd_pkg::QDEPTH - 2));
    assign o_out.valid      = (r_count != '0);
    assign o_out.pcm_sample = r_mem[r_rd].sample;
    assign o_out.final_sample = r_mem[r_rd].final_s;
    assign pop              = o_out.valid && o_out.ready;
    assign wr1              = r_wr + drbd_pkg::QPTR_W'(1);

    always_comb begin
        n_count = r_count + drbd_pkg::QCNT_QW'(i_push.n) - drbd_pkg::QCNT_QW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != '0) begin
            r_mem[r_wr] <= i_push.e0;
        end
        if (i_push.n == drbd_pkg::PUSH_W'(2)) begin
            r_mem[wr1] <= i_push.e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + drbd_pkg::QPTR_W'(i_push.n);
            r_rd    <= r_rd + drbd_pkg::QPTR_W'(pop);
            r_count <= n_count;
        end
    end

    `DRBD_ASSERT_ALWAYS(a_count_bound, r_count <= drbd_pkg::QCNT_QW'(drbd_pkg::QDEPTH))
    `DRBD_ASSERT_ALWAYS(a_push_room, (i_push.n == '0) || o_room2)
    `DRBD_ASSERT_NEXT(a_pop_only, pop && i_push.n == '0, r_count == $past(r_count) - drbd_pkg::QCNT_QW'(1))

endmodule

/* rtl/core/delta_rice_byte_decoder_unit.sv */
// Channel    Dir  Payload                          Beat when
// i_in       in   code_byte[7:0], stream_end       valid & ready
// o_out      out  pcm_sample[15:0], final_sample   valid & ready
// i_cfg_*    in   start_sample (i_cfg_wdata)       i_cfg_we
//
// One code byte per cycle while the queue has room for two samples. A byte is
// held in the input register, then decoded and pushed into a 4-entry result
// queue, whose head drives the output channel.
// The stream-start byte can yield two samples and then occupies the output
// side for two beats; the queue absorbs that.
// Reset (sync, active low) clears decode state, queue and start_sample.
// Input stalls when the input register holds a byte and the queue lacks room
// for two samples; output stalls just let the queue fill.
module delta_rice_byte_decoder_unit #(
    parameter int RICE_K = drbd_pkg::RICE_K
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    drbd_in_if.sink                        i_in,
    drbd_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [drbd_pkg::SAMPLE_W-1:0]  i_cfg_wdata
);

    // input register
    logic                          r_in_vld;
    logic [drbd_pkg::BYTE_W-1:0]   r_byte;
    logic                          r_end;
    // configured start sample
    drbd_pkg::t_sample             r_start_sample;

    logic                          room2;
    logic                          fire;
    drbd_pkg::t_push               push;

    // decode fires when the queue can take the worst case of two samples
    assign fire       = r_in_vld && room2;
    assign i_in.ready = !r_in_vld || fire;

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.code_byte;
            r_end  <= i_in.stream_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld       <= 1'b0;
            r_start_sample <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (i_cfg_we) begin
                r_start_sample <= drbd_pkg::t_sample'(i_cfg_wdata);
            end
        end
    end

    drbd_step #(
        .RICE_K (RICE_K)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_byte),
        .i_end   (r_end),
        .i_start (r_start_sample),
        .o_push  (push)
    );

    drbd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_out   (o_out)
    );

endmodule
